// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/fnws_pkg.sv =====
// ----------------------------------------------------------------------------
// fnws_pkg
// Widths, constants and shared types of the synthesizer word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fnws_pkg;

  localparam int FRAC_BITS_DEF = 24;

  // field widths
  localparam int FREQ_W = 23;
  localparam int WORD_W = 28;
  localparam int IDX_W  = 5;
  localparam int DATA_W = 24;
  localparam int ADDR_W = 4;
  localparam int REF_W  = 19;
  localparam int CP_W   = 7;
  localparam int VCO_W  = 16;
  localparam int RDIV_W = 14;
  localparam int NUM_W  = 36;   // fv2 * R stays below 2^36
  localparam int PROD_W = FREQ_W + RDIV_W;
  localparam int LIM_W  = 25;   // 40 * ref
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = REF_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_KHZ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CP_CUR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_MID  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_HIGH = 3'd4;

  localparam logic [REF_W-1:0] REF_RESET = 19'd50000;

  // band limits in kHz, inclusive
  localparam logic [FREQ_W-1:0] MID_LO  = 23'd2100000;
  localparam logic [FREQ_W-1:0] MID_HI  = 23'd2410000;
  localparam logic [FREQ_W-1:0] LOW_LO  = 23'd1050000;
  localparam logic [FREQ_W-1:0] LOW_HI  = 23'd1205000;
  localparam logic [FREQ_W-1:0] HIGH_LO = 23'd4200000;
  localparam logic [FREQ_W-1:0] HIGH_HI = 23'd4820000;
  localparam logic [FREQ_W-1:0] FV2_DEF = 23'd4600000;   // 2300 MHz in half kHz

  localparam logic [RDIV_W-1:0] RDIV_MAX = 14'd8192;
  localparam logic [IDX_W-1:0]  WIDX_LAST = 5'd17;

  // serial register addresses
  localparam logic [ADDR_W-1:0] ADDR_ID   = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_RST  = 4'h1;
  localparam logic [ADDR_W-1:0] ADDR_RDIV = 4'h2;
  localparam logic [ADDR_W-1:0] ADDR_NINT = 4'h3;
  localparam logic [ADDR_W-1:0] ADDR_NFRC = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_VCO  = 4'h5;
  localparam logic [ADDR_W-1:0] ADDR_SD   = 4'h6;
  localparam logic [ADDR_W-1:0] ADDR_LD   = 4'h7;
  localparam logic [ADDR_W-1:0] ADDR_ALG  = 4'h8;
  localparam logic [ADDR_W-1:0] ADDR_CP   = 4'h9;
  localparam logic [ADDR_W-1:0] ADDR_AUX  = 4'hA;
  localparam logic [ADDR_W-1:0] ADDR_GPO  = 4'hB;
  localparam logic [ADDR_W-1:0] ADDR_RSVC = 4'hC;
  localparam logic [ADDR_W-1:0] ADDR_RSVD = 4'hD;
  localparam logic [ADDR_W-1:0] ADDR_GPOB = 4'hF;

  // data constants
  localparam logic [DATA_W-1:0] D_ID      = 24'h000020;
  localparam logic [DATA_W-1:0] D_SD      = 24'h202F4A;
  localparam logic [DATA_W-1:0] D_BIAS_LO = 24'h00AB95;
  localparam logic [DATA_W-1:0] D_BIAS_HI = 24'h00A395;
  localparam logic [DATA_W-1:0] D_VCO_CFG = 24'h00D11D;
  localparam logic [DATA_W-1:0] D_VCO_END = 24'h000005;
  localparam logic [DATA_W-1:0] D_RST     = 24'h000002;
  localparam logic [DATA_W-1:0] D_LD      = 24'h00010D;
  localparam logic [DATA_W-1:0] D_ALG     = 24'h41BEFF;
  localparam logic [DATA_W-1:0] D_AUX     = 24'h001105;
  localparam logic [DATA_W-1:0] D_GPO     = 24'h078061;
  localparam logic [DATA_W-1:0] D_GPOB    = 24'h000081;
  localparam logic [6:0]        CP_OFFSET = 7'h5F;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // everything the word builder needs
  typedef struct packed {
    logic [RDIV_W-1:0] rdiv;
    logic [CP_W-1:0]   cp;
    logic [VCO_W-1:0]  band;
    logic              hi_band;
    logic [DATA_W-1:0] nint;
    logic [DATA_W-1:0] nfrac;
  } word_fields_t;

endpackage

`default_nettype wire

// ===== rtl/core/fnws_if.sv =====
// ----------------------------------------------------------------------------
// fnws_in_if / fnws_out_if
// Valid/ready channels for frequency requests and register words.
// ----------------------------------------------------------------------------
`default_nettype none

interface fnws_in_if;
  logic                       valid;
  logic                       ready;
  logic [fnws_pkg::FREQ_W-1:0] freq_khz;

  modport source (output valid, output freq_khz, input ready);
  modport sink   (input valid, input freq_khz, output ready);
endinterface

interface fnws_out_if;
  logic                       valid;
  logic                       ready;
  logic [fnws_pkg::WORD_W-1:0] spi_word;
  logic [fnws_pkg::IDX_W-1:0]  word_index;
  logic                       last_word;

  modport source (output valid, output spi_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input spi_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/frac_n_synth_word_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// frac_n_synth_word_sequencer_top
// Turns a requested frequency into the 18-word register programming sequence.
// ----------------------------------------------------------------------------
// A request beat on in_ch starts one sequence; in_ch.ready stays low until the
// last of its 18 words has been taken on out_ch. A request then passes through
// the accept cycle, where the band is picked, the product state, the
// divider-check state, the serial restoring divider that yields one quotient
// bit of N per cycle, the rounding state, then one word per cycle while
// out_ch.ready is high. The reference divider R is kept across requests and
// may double once per request.
`default_nettype none

`include "assert_macros.svh"

module frac_n_synth_word_sequencer_top #(
  parameter int FRAC_BITS = fnws_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  fnws_in_if.sink                                   in_ch,
  fnws_out_if.source                                out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [fnws_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [fnws_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int DW     = fnws_pkg::NUM_W + FRAC_BITS;
  localparam int DATA_W = fnws_pkg::DATA_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_RND  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [fnws_pkg::REF_W-1:0]  ref_r;
  logic [fnws_pkg::CP_W-1:0]   cp_r;
  logic [fnws_pkg::VCO_W-1:0]  vco_mid_r, vco_low_r, vco_high_r;
  logic [fnws_pkg::RDIV_W-1:0] rdiv_r;
  logic [fnws_pkg::IDX_W-1:0]  idx_r;

  logic [fnws_pkg::FREQ_W-1:0] fv2_r;
  logic [fnws_pkg::VCO_W-1:0]  band_r;
  logic                        hi_r;
  logic [fnws_pkg::PROD_W-1:0] prod_r;
  logic [DATA_W-1:0]           nint_r, nfrac_r;

  logic in_beat, out_beat;

  // band selection on the incoming request
  logic [fnws_pkg::FREQ_W-1:0] f_in, fv2_sel;
  logic [fnws_pkg::VCO_W-1:0]  band_sel;
  logic                        hi_sel;

  // divider check
  logic [fnws_pkg::REF_W-1:0]  ref_eff;
  logic [fnws_pkg::LIM_W-1:0]  lim;
  logic                        dbl;

  // rounding
  logic [DW:0]   q_inc;
  logic [DW-1:0] t_val;

  fnws_pkg::div_ctrl_t    div_ctrl;
  fnws_pkg::div_stat_t    div_stat;
  logic [DW-1:0]          quot;
  fnws_pkg::word_fields_t fields;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;

  always_comb begin
    f_in     = in_ch.freq_khz;
    fv2_sel  = fnws_pkg::FV2_DEF;
    band_sel = vco_mid_r;
    hi_sel   = 1'b0;
    if (f_in >= fnws_pkg::MID_LO && f_in <= fnws_pkg::MID_HI) begin
      fv2_sel = {f_in[fnws_pkg::FREQ_W-2:0], 1'b0};
    end else if (f_in >= fnws_pkg::LOW_LO && f_in <= fnws_pkg::LOW_HI) begin
      fv2_sel  = {f_in[fnws_pkg::FREQ_W-3:0], 2'b00};
      band_sel = vco_low_r;
    end else if (f_in >= fnws_pkg::HIGH_LO && f_in <= fnws_pkg::HIGH_HI) begin
      fv2_sel  = f_in;
      band_sel = vco_high_r;
      hi_sel   = 1'b1;
    end
  end

  // zero reference reads as 1; lim = 20 * (2 * ref)
  always_comb begin
    ref_eff = (ref_r == '0) ? fnws_pkg::REF_W'(1) : ref_r;
    lim     = {ref_eff, 5'b0} + {2'b0, ref_eff, 3'b0};
    dbl     = (prod_r < fnws_pkg::PROD_W'(lim)) && (rdiv_r < fnws_pkg::RDIV_MAX);
  end

  // round to nearest: t = (q + 1) / 2
  always_comb begin
    q_inc = {1'b0, quot} + (DW + 1)'(1);
    t_val = q_inc[DW:1];
  end

  assign div_ctrl.start = (state_r == ST_CHK);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_beat) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_CHK;
      ST_CHK:  state_nxt = ST_DIV;
      ST_DIV:  if (div_stat.done) state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_EMIT;
      ST_EMIT: if (out_beat && idx_r == fnws_pkg::WIDX_LAST) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      rdiv_r     <= fnws_pkg::RDIV_W'(1);
      ref_r      <= fnws_pkg::REF_RESET;
      cp_r       <= '0;
      vco_mid_r  <= '0;
      vco_low_r  <= '0;
      vco_high_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CHK && dbl) begin
        rdiv_r <= {rdiv_r[fnws_pkg::RDIV_W-2:0], 1'b0};
      end
      if (state_r == ST_RND) begin
        idx_r <= '0;
      end else if (out_beat) begin
        idx_r <= idx_r + fnws_pkg::IDX_W'(1);
      end
      // configuration writes
      if (cfg_we) begin
        case (cfg_idx)
          fnws_pkg::CFG_REF_KHZ:  ref_r      <= cfg_wdata;
          fnws_pkg::CFG_CP_CUR:   cp_r       <= cfg_wdata[fnws_pkg::CP_W-1:0];
          fnws_pkg::CFG_VCO_MID:  vco_mid_r  <= cfg_wdata[fnws_pkg::VCO_W-1:0];
          fnws_pkg::CFG_VCO_LOW:  vco_low_r  <= cfg_wdata[fnws_pkg::VCO_W-1:0];
          fnws_pkg::CFG_VCO_HIGH: vco_high_r <= cfg_wdata[fnws_pkg::VCO_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      fv2_r  <= fv2_sel;
      band_r <= band_sel;
      hi_r   <= hi_sel;
    end
    if (state_r == ST_MUL) begin
      prod_r <= fv2_r * rdiv_r;
    end
    if (state_r == ST_RND) begin
      nint_r  <= t_val[FRAC_BITS +: DATA_W];
      nfrac_r <= DATA_W'(t_val[FRAC_BITS-1:0]) << (DATA_W - FRAC_BITS);
    end
  end

  // the divider loads the product with the new R in the check cycle
  logic [fnws_pkg::NUM_W-1:0] num_start;
  assign num_start = dbl ? {prod_r[fnws_pkg::NUM_W-2:0], 1'b0}
                         : prod_r[fnws_pkg::NUM_W-1:0];

  fnws_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (div_ctrl),
    .num     (num_start),
    .divisor (ref_eff),
    .stat    (div_stat),
    .quot    (quot)
  );

  assign fields.rdiv    = rdiv_r;
  assign fields.cp      = cp_r;
  assign fields.band    = band_r;
  assign fields.hi_band = hi_r;
  assign fields.nint    = nint_r;
  assign fields.nfrac   = nfrac_r;

  fnws_word u_word (
    .idx      (idx_r),
    .fields   (fields),
    .spi_word (out_ch.spi_word)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = (state_r == ST_EMIT);
  assign out_ch.word_index = idx_r;
  assign out_ch.last_word  = (idx_r == fnws_pkg::WIDX_LAST);

  // checks
  `ASSERT_NXT(a_busy_after_req, in_beat, !in_ch.ready)
  `ASSERT_NXT(a_idle_after_last, out_beat && out_ch.last_word, in_ch.ready)
  `ASSERT_IMP(a_no_overlap, out_ch.valid, !in_ch.ready && !div_stat.busy)
  `ASSERT_IMP(a_rdiv_pow2, 1'b1, $onehot(rdiv_r))

endmodule

`default_nettype wire

// ===== rtl/core/fnws_div.sv =====
// ----------------------------------------------------------------------------
// fnws_div
// Restoring divider, one quotient bit per cycle, dividend = num << FRAC_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module fnws_div #(
  parameter int FRAC_BITS = fnws_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire fnws_pkg::div_ctrl_t               ctrl,
  input  wire logic [fnws_pkg::NUM_W-1:0]        num,
  input  wire logic [fnws_pkg::REF_W-1:0]        divisor,
  output fnws_pkg::div_stat_t                    stat,
  output logic [fnws_pkg::NUM_W+FRAC_BITS-1:0]   quot
);

  localparam int DW    = fnws_pkg::NUM_W + FRAC_BITS;
  localparam int RW    = fnws_pkg::REF_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    d_r, d_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [RW:0] rem_ext;
  logic [RW:0] diff;
  logic        ge;

  // one trial subtraction per cycle
  always_comb begin
    rem_ext = {rem_r, d_r[DW-1]};
    diff    = rem_ext - {1'b0, dvs_r};
    ge      = (rem_ext >= {1'b0, dvs_r});
  end

  always_comb begin
    cnt_nxt = cnt_r;
    d_nxt   = d_r;
    rem_nxt = rem_r;
    if (ctrl.start) begin
      cnt_nxt = CNT_W'(DW);
      d_nxt   = {num, {FRAC_BITS{1'b0}}};
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      d_nxt   = {d_r[DW-2:0], ge};
      rem_nxt = ge ? diff[RW-1:0] : rem_ext[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    if (ctrl.start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = (cnt_r == CNT_W'(1));
  assign quot      = d_r;

endmodule

`default_nettype wire

// ===== rtl/core/fnws_word.sv =====
// ----------------------------------------------------------------------------
// fnws_word
// Builds the register word (address over data) for a sequence position.
// ----------------------------------------------------------------------------
`default_nettype none

module fnws_word (
  input  wire logic [fnws_pkg::IDX_W-1:0]  idx,
  input  wire fnws_pkg::word_fields_t      fields,
  output logic [fnws_pkg::WORD_W-1:0]      spi_word
);

  logic [fnws_pkg::DATA_W-1:0] cpw;

  // charge pump: enable bits, fixed offset, then up and down currents
  assign cpw = {3'b110, fnws_pkg::CP_OFFSET, fields.cp, fields.cp};

  always_comb begin
    case (idx)
      5'd0:  spi_word = {fnws_pkg::ADDR_ID, fnws_pkg::D_ID};
      5'd1:  spi_word = {fnws_pkg::ADDR_RDIV,
                         fnws_pkg::DATA_W'(fields.rdiv)};
      5'd2:  spi_word = {fnws_pkg::ADDR_SD, fnws_pkg::D_SD};
      5'd3:  spi_word = {fnws_pkg::ADDR_CP, cpw};
      5'd4:  spi_word = {fnws_pkg::ADDR_VCO,
                         fnws_pkg::DATA_W'(fields.band)};
      5'd5:  spi_word = {fnws_pkg::ADDR_VCO,
                         fields.hi_band ? fnws_pkg::D_BIAS_HI : fnws_pkg::D_BIAS_LO};
      5'd6:  spi_word = {fnws_pkg::ADDR_VCO, fnws_pkg::D_VCO_CFG};
      5'd7:  spi_word = {fnws_pkg::ADDR_VCO, fnws_pkg::D_VCO_END};
      5'd8:  spi_word = {fnws_pkg::ADDR_RST, fnws_pkg::D_RST};
      5'd9:  spi_word = {fnws_pkg::ADDR_LD, fnws_pkg::D_LD};
      5'd10: spi_word = {fnws_pkg::ADDR_ALG, fnws_pkg::D_ALG};
      5'd11: spi_word = {fnws_pkg::ADDR_AUX, fnws_pkg::D_AUX};
      5'd12: spi_word = {fnws_pkg::ADDR_GPO, fnws_pkg::D_GPO};
      5'd13: spi_word = {fnws_pkg::ADDR_RSVC, {fnws_pkg::DATA_W{1'b0}}};
      5'd14: spi_word = {fnws_pkg::ADDR_RSVD, {fnws_pkg::DATA_W{1'b0}}};
      5'd15: spi_word = {fnws_pkg::ADDR_GPOB, fnws_pkg::D_GPOB};
      5'd16: spi_word = {fnws_pkg::ADDR_NINT, fields.nint};
      5'd17: spi_word = {fnws_pkg::ADDR_NFRC, fields.nfrac};
      default: spi_word = '0;
    endcase
  end

endmodule

`default_nettype wire
